@@ rtl/core/plc_pkg.sv @@
// Package with the shared types, codes and constants of the positional list.
package plc_pkg;

  // Default list capacity and the longest read-out that is emitted.
  localparam int CAPACITY_DEF = 64;
  localparam int MAX_OUT      = 64;

  // Width of slot indexes and counts inside the cell chain, enough for 1024 entries.
  localparam int IDX_W = 11;

  // Operation codes of an input word.
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  // Commands that every cell of the chain sees.
  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_ROTATE = 3'd4;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         position;
    logic signed [31:0] element;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [5:0]         slot;
    logic [6:0]         fill;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] lim;
    logic [31:0]      elem;
  } cell_ctl_t;

endpackage

@@ rtl/core/plc_chan_if.sv @@
// Valid/ready channel interface that carries one word per handshake.
interface plc_chan_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/plc_cell.sv @@
// One storage cell of the list chain, holding the entry of a fixed slot.
module plc_cell #(
  parameter int Idx = 0
) (
  input  logic             clk,
  input  plc_pkg::cell_ctl_t ctl,
  input  logic [31:0]      left_data,
  input  logic [31:0]      right_data,
  input  logic [31:0]      head_data,
  output logic [31:0]      data
);
  import plc_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx  = IDX_W'(Idx);
  localparam logic [IDX_W-1:0] MyNext = IDX_W'(Idx + 1);

  logic [31:0] data_r;
  logic [31:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_APPEND: begin
        if (MyIdx == ctl.lim) data_nxt = ctl.elem;
      end
      OP_INSERT: begin
        if (MyIdx == ctl.pos) begin
          data_nxt = ctl.elem;
        end else if (MyIdx > ctl.pos) begin
          data_nxt = left_data;
        end
      end
      OP_DELETE: begin
        if (MyIdx >= ctl.pos) data_nxt = right_data;
      end
      OP_ROTATE: begin
        // The filled part of the chain turns by one slot toward the head.
        if (MyNext == ctl.lim) begin
          data_nxt = head_data;
        end else if (MyNext < ctl.lim) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

@@ rtl/core/positional_list_insert_delete.sv @@
// Top level of the positional list: control, fill count and the chain of entry cells.
// An edit word's result word is registered and offered in the cycle after the word is accepted.
// Throughput: one edit word per cycle while the output is not stalled. A read-out of a
// non-empty list holds the input until it ends and gives one result word per cycle for the
// first MAX_OUT entries while the output takes them; each step turns the chain past the head.
// Reset is synchronous and active low; it empties the list and drops any pending result.
module positional_list_insert_delete #(
  parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  plc_chan_if.sink   in_ch,
  plc_chan_if.source out_ch
);
  import plc_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  // Controller states.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_data_r, out_data_nxt;

  in_word_t      in_word;
  cell_ctl_t     ctl;
  logic [31:0]   cell_data [CAPACITY];
  logic [IDX_W-1:0] count_x;
  logic [IDX_W-1:0] pos_x;
  logic          slot_free;
  logic          accept;
  logic          list_full;

  assign in_word   = in_ch.data;
  assign count_x   = IDX_W'(count_r);
  assign pos_x     = IDX_W'(in_word.position);
  assign list_full = (count_x == IDX_W'(CAPACITY));

  // The output register frees up when it is empty or its word leaves this cycle.
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && slot_free;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    out_word_t res;
    logic      emit;

    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    ctl.op        = OP_HOLD;
    ctl.pos       = pos_x;
    ctl.lim       = count_x;
    ctl.elem      = in_word.element;
    res           = '0;
    res.status    = ST_OK;
    res.last      = 1'b1;
    emit          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          case (in_word.action)
            ACT_APPEND: begin
              if (list_full) begin
                res.status = ST_FULL;
              end else begin
                ctl.op    = OP_APPEND;
                count_nxt = count_r + CW'(1);
              end
            end
            ACT_INSERT: begin
              // The full check takes precedence over the position check.
              if (list_full) begin
                res.status = ST_FULL;
              end else if (pos_x > count_x) begin
                res.status = ST_BADPOS;
              end else begin
                ctl.op    = OP_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            ACT_DELETE: begin
              if (count_r == '0) begin
                res.status = ST_EMPTY;
              end else if (pos_x >= count_x) begin
                res.status = ST_BADPOS;
              end else begin
                ctl.op    = OP_DELETE;
                count_nxt = count_r - CW'(1);
              end
            end
            ACT_READ: begin
              // An empty list answers with a single empty status word.
              if (count_r == '0) begin
                res.status = ST_EMPTY;
              end else begin
                emit       = 1'b0;
                state_nxt  = ST_READ;
                rd_idx_nxt = '0;
              end
            end
            default: res.status = ST_OK;
          endcase
          res.fill = 7'(count_nxt);
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = res;
          end
        end
      end
      ST_READ: begin
        // Each step shows the head cell and turns the filled part of the chain by one.
        // After count steps the list is back in its original order. Entries past the
        // first MAX_OUT are turned through without being shown.
        if (slot_free) begin
          ctl.op     = OP_ROTATE;
          rd_idx_nxt = rd_idx_r + CW'(1);
          if (32'(rd_idx_r) < MAX_OUT) begin
            res.status    = ST_OK;
            res.value     = cell_data[0];
            res.slot      = 6'(rd_idx_r);
            res.fill      = 7'(count_r);
            res.last      = (32'(rd_idx_r) + 1 == 32'(count_r)) ||
                            (32'(rd_idx_r) == MAX_OUT - 1);
            out_valid_nxt = 1'b1;
            out_data_nxt  = res;
          end
          if (32'(rd_idx_r) + 1 == 32'(count_r)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // The chain of cells: each slot sees its neighbors and the head cell.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [31:0] left_data;
    logic [31:0] right_data;

    if (g == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right_data = cell_data[g];
    end else begin : g_mid_r
      assign right_data = cell_data[g+1];
    end

    plc_cell #(
      .Idx (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_data),
      .right_data (right_data),
      .head_data  (cell_data[0]),
      .data       (cell_data[g])
    );
  end

endmodule

@@ rtl/core/plc_checker.sv @@
// Port-level checker for the positional list, bound to the top level.
module plc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_value,
  input logic [5:0]  out_slot,
  input logic        out_last
);
  import plc_pkg::*;

  // A result word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // Refused operations give a single word with no value and no slot.
  a_refused_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_value == '0 && out_slot == '0)
    else $error("refused operation gave a malformed result");

  // No new word is taken while a read-out still has words to give.
  a_readout_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready && out_status == ST_OK)
    else $error("input taken in the middle of a read-out");

  // Read-out words follow each other without gaps and with rising slots.
  a_readout_slots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_slot == 6'($past(out_slot) + 6'd1))
    else $error("read-out slot sequence broken");

endmodule

bind positional_list_insert_delete plc_checker u_plc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.data.status),
  .out_value  (out_ch.data.value),
  .out_slot   (out_ch.data.slot),
  .out_last   (out_ch.data.last)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the positional list: directed edits, full-list cases and random traffic.
module testbench;
  import plc_pkg::*;

  // The list under test uses the default capacity, which equals the longest read-out.
  localparam int DEPTH       = CAPACITY_DEF;
  // Percentage of cycles in which either side idles when traffic is irregular.
  localparam int IDLE_PCT    = 17;
  // Cycles granted to the whole run. The slowest correct run is far below this.
  localparam int CYCLE_LIMIT = 400000;
  // Receiver hold-off that lets the block back up and stall its input.
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n;

  plc_chan_if #(.word_t(in_word_t))  in_ch ();
  plc_chan_if #(.word_t(out_word_t)) out_ch ();

  positional_list_insert_delete #(
    .CAPACITY(DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the list. Only slots below list_len ever hold meaning.
  logic signed [31:0] list_mem [DEPTH];
  int unsigned        list_len;

  // Result words predicted for accepted input words, oldest first.
  out_word_t   pending_results [$];
  int unsigned error_count = 0;
  int unsigned cycle_count;

  // When set, neither side idles. hold_left counts down a receiver hold-off.
  bit          steady_flow = 1'b0;
  int unsigned hold_left   = 0;

  always #1 clk = ~clk;

  // Works out the result words that one accepted input word causes and updates
  // the shadow list. Edits always give exactly one word; a read-out of a
  // non-empty list gives one word per entry with last set on the final one.
  function automatic void model_list_op(input in_word_t w);
    out_word_t   r;
    int unsigned n;
    int unsigned i;
    r      = '0;
    r.last = 1'b1;
    case (w.action)
      ACT_APPEND: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = w.element;
          list_len++;
          r.status = ST_OK;
        end
      end
      ACT_INSERT: begin
        // The full check comes before the position check.
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (w.position > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = list_len; i > w.position; i--) begin
            list_mem[i] = list_mem[i - 1];
          end
          list_mem[w.position] = w.element;
          list_len++;
          r.status = ST_OK;
        end
      end
      ACT_DELETE: begin
        // The empty check comes before the position check.
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (w.position >= list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = w.position; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i + 1];
          end
          list_len--;
          r.status = ST_OK;
        end
      end
      ACT_READ: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          n = (list_len < MAX_OUT) ? list_len : MAX_OUT;
          for (i = 0; i < n; i++) begin
            r.status = ST_OK;
            r.value  = list_mem[i];
            r.slot   = 6'(i);
            r.fill   = 7'(list_len);
            r.last   = (i + 1 == n);
            pending_results.push_back(r);
          end
          return;
        end
      end
    endcase
    r.fill = 7'(list_len);
    pending_results.push_back(r);
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("mismatch at cycle %0d: %s expected 0x%0h, got 0x%0h",
             cycle_count, what, want, got);
    error_count++;
  endtask

  // Offers one input word. The task is entered and left at a falling edge, so
  // valid is written once per time step: it stays high into the next word
  // unless an idle cycle is drawn. The word is predicted at the rising edge
  // where the handshake completes.
  task automatic push_word(input logic [1:0] action, input logic [5:0] position,
                           input logic signed [31:0] element);
    in_word_t w;
    w.action   = action;
    w.position = position;
    w.element  = element;
    while (!steady_flow && ($urandom_range(99) < IDLE_PCT)) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    model_list_op(w);
    @(negedge clk);
  endtask

  // Random element with the extremes of the signed range drawn now and then.
  function automatic logic signed [31:0] random_element();
    case ($urandom_range(19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return 32'shFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Reads, deletes and inserts against an empty list, plus one insert at the
  // only legal slot and its removal.
  task automatic test_empty_list();
    push_word(ACT_READ,   6'd0,  32'sd0);
    push_word(ACT_DELETE, 6'd0,  32'sd0);
    push_word(ACT_DELETE, 6'd63, 32'sd0);
    push_word(ACT_INSERT, 6'd1,  32'sd5);
    push_word(ACT_INSERT, 6'd0,  32'sd0);
    push_word(ACT_DELETE, 6'd0,  32'sd0);
  endtask

  // Extreme elements, inserts at the head and just past the tail, refused
  // positions for both edits, deletes at head, middle and tail, and read-outs.
  task automatic test_edge_values();
    push_word(ACT_APPEND, 6'd0,  32'sh7FFF_FFFF);
    push_word(ACT_APPEND, 6'd0,  32'sh8000_0000);
    push_word(ACT_INSERT, 6'd0,  32'shFFFF_FFFF);
    push_word(ACT_INSERT, 6'd3,  32'sh0000_0000);
    push_word(ACT_INSERT, 6'd5,  32'sh1234_5678);
    push_word(ACT_INSERT, 6'd63, 32'sh5555_AAAA);
    push_word(ACT_DELETE, 6'd4,  32'sd0);
    push_word(ACT_DELETE, 6'd63, 32'sd0);
    push_word(ACT_READ,   6'd63, 32'shFFFF_FFFF);
    push_word(ACT_DELETE, 6'd1,  32'sd0);
    push_word(ACT_DELETE, 6'd2,  32'sd0);
    push_word(ACT_DELETE, 6'd0,  32'sd0);
    push_word(ACT_READ,   6'd0,  32'sd0);
    push_word(ACT_DELETE, 6'd0,  32'sd0);
  endtask

  // Fills the list to capacity with random content, then checks the refusals
  // of a full list, the longest read-out and edits at the top slot.
  task automatic test_full_list();
    while (list_len < DEPTH) begin
      if ($urandom_range(1)) begin
        push_word(ACT_APPEND, 6'($urandom_range(63)), random_element());
      end else begin
        push_word(ACT_INSERT, 6'($urandom_range(list_len)), random_element());
      end
    end
    push_word(ACT_APPEND, 6'd0,  random_element());
    push_word(ACT_INSERT, 6'd0,  random_element());
    // A full list also refuses an insert at the top slot as full.
    push_word(ACT_INSERT, 6'd63, random_element());
    push_word(ACT_READ,   6'd0,  32'sd0);
    push_word(ACT_DELETE, 6'd63, 32'sd0);
    push_word(ACT_INSERT, 6'd63, random_element());
    push_word(ACT_DELETE, 6'd0,  32'sd0);
    push_word(ACT_READ,   6'd0,  32'sd0);
    while (list_len > 8) begin
      push_word(ACT_DELETE, 6'($urandom_range(list_len - 1)), 32'sd0);
    end
  endtask

  // Mostly well-formed edits that keep the fill wandering over the whole range,
  // some read-outs, and some words with an arbitrary operation and position.
  task automatic test_random_ops(input int unsigned n_words);
    int unsigned roll;
    int unsigned grow_pct;
    repeat (n_words) begin
      roll = $urandom_range(99);
      if (list_len < 16) begin
        grow_pct = 70;
      end else if (list_len > 48) begin
        grow_pct = 30;
      end else begin
        grow_pct = 50;
      end
      if (roll < 7) begin
        push_word(ACT_READ, 6'($urandom_range(63)), random_element());
      end else if (roll < 20) begin
        push_word(2'($urandom_range(3)), 6'($urandom_range(63)), random_element());
      end else if ($urandom_range(99) < grow_pct) begin
        if ($urandom_range(1)) begin
          push_word(ACT_APPEND, 6'($urandom_range(63)), random_element());
        end else begin
          push_word(ACT_INSERT, 6'($urandom_range(list_len)), random_element());
        end
      end else begin
        push_word(ACT_DELETE, 6'((list_len == 0) ? 0 : $urandom_range(list_len - 1)),
                  random_element());
      end
    end
  endtask

  // The receiver holds off while the sender keeps offering words, so the block
  // backs up and drops its input ready.
  task automatic test_backpressure();
    hold_left = HOLD_CYCLES;
    test_random_ops(24);
  endtask

  // A stretch without any idling on either side.
  task automatic test_steady_stream();
    steady_flow = 1'b1;
    test_random_ops(30);
    steady_flow = 1'b0;
  endtask

  // Result ready, updated at each falling edge. A hold-off takes precedence
  // over the random idling.
  initial begin : result_ready_drive
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compares every accepted result word, field by field, with the oldest
  // prediction.
  initial begin : result_monitor
    out_word_t want;
    out_word_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) report_mismatch("status", want.status, got.status);
          if (got.value  !== want.value)  report_mismatch("value",  want.value,  got.value);
          if (got.slot   !== want.slot)   report_mismatch("slot",   want.slot,   got.slot);
          if (got.fill   !== want.fill)   report_mismatch("fill",   want.fill,   got.fill);
          if (got.last   !== want.last)   report_mismatch("last",   want.last,   got.last);
        end
      end
    end
  end

  // Ends the run if the traffic does not drain in time.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    list_len    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_list();
    test_edge_values();
    test_full_list();
    test_random_ops(30);
    test_backpressure();
    test_steady_stream();

    in_ch.valid <= 1'b0;
    // Wait for every predicted word, then keep the clock running so that a stray
    // extra word would still show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/plc_pkg.sv
rtl/core/plc_chan_if.sv
rtl/core/plc_cell.sv
rtl/core/positional_list_insert_delete.sv
rtl/core/plc_checker.sv
bench/testbench.sv
